/* rtl/mmh_pkg.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 string hash package
// Shared constants, operation codes and control/status types.
// ----------------------------------------------------------------------------
package mmh_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int MSG_LEN_W   = 16;
    localparam int BYTE_W      = 8;
    localparam int HASH_W      = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [HASH_W-1:0] MIX_MUL       = 32'h5bd1e995;
    localparam int                MIX_SHIFT     = 24;
    localparam int                FINAL_SHIFT_A = 13;
    localparam int                FINAL_SHIFT_B = 15;

    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE = 1'd1;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_MIX_K1 = 3'd1;
    localparam logic [OP_W-1:0] OP_MIX_K2 = 3'd2;
    localparam logic [OP_W-1:0] OP_MIX_H  = 3'd3;
    localparam logic [OP_W-1:0] OP_TAIL   = 3'd4;
    localparam logic [OP_W-1:0] OP_FINAL  = 3'd5;
    localparam logic [OP_W-1:0] OP_EMIT   = 3'd6;

    typedef struct packed {
        logic            take;
        logic [OP_W-1:0] op;
    } mmh_cmd_t;

    typedef struct packed {
        logic absorb;
        logic word_full;
        logic last;
        logic empty;
        logic out_free;
    } mmh_stat_t;

endpackage

/* rtl/mmh_in_if.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 input channel
// Valid/ready channel that carries one string byte per item.
// ----------------------------------------------------------------------------
interface mmh_in_if;
    logic                         valid;
    logic                         ready;
    logic [mmh_pkg::BYTE_W-1:0]   char_byte;
    logic                         start_of_message;
    logic [mmh_pkg::MSG_LEN_W-1:0] message_length;

    modport source (output valid, output char_byte, output start_of_message,
                    output message_length, input ready);
    modport sink   (input valid, input char_byte, input start_of_message,
                    input message_length, output ready);
endinterface

/* rtl/mmh_out_if.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 output channel
// Valid/ready channel that carries one finished hash per item.
// ----------------------------------------------------------------------------
interface mmh_out_if;
    logic                       valid;
    logic                       ready;
    logic [mmh_pkg::HASH_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

/* rtl/murmur2_string_hash_top.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 string hash top level
// 32-bit MurmurHash2 of a byte string that arrives one byte per item.
//
//   channel   | dir | payload                                        | items
//   item_in   | in  | char_byte, start_of_message, message_length    | bytes
//   hash_out  | out | hash_value                                     | hashes
//   cfg       | in  | cfg_we, cfg_index, cfg_data                    | writes
//
// A byte is taken while the controller idles; every fourth byte of a message
// adds the word mix on the single shared 32x32 multiplier. Message end adds a
// tail step (when 1-3 bytes remain), a final mix and an output load.
// The output register holds a hash while the next message streams in;
// only the output load waits on hash_out.ready. Reset clears all control.
// ----------------------------------------------------------------------------
module murmur2_string_hash_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mmh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mmh_pkg::CFG_DATA_W-1:0] cfg_data,
    mmh_in_if.sink                         item_in,
    mmh_out_if.source                      hash_out
);

    mmh_pkg::mmh_cmd_t  cmd;
    mmh_pkg::mmh_stat_t stat;

    mmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (item_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mmh_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .char_byte        (item_in.char_byte),
        .start_of_message (item_in.start_of_message),
        .message_length   (item_in.message_length),
        .out_ready        (hash_out.ready),
        .out_valid        (hash_out.valid),
        .hash_value       (hash_out.hash_value),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

/* rtl/mmh_ctrl.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 controller
// Sequences byte intake, word mixing, tail, final mix and result hand-off.
// ----------------------------------------------------------------------------
module mmh_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mmh_pkg::mmh_stat_t stat,
    output mmh_pkg::mmh_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MIX_K1 = 3'd1;
    localparam logic [2:0] S_MIX_K2 = 3'd2;
    localparam logic [2:0] S_MIX_H  = 3'd3;
    localparam logic [2:0] S_TAIL   = 3'd4;
    localparam logic [2:0] S_FINAL  = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        in_ready   = 1'b0;
        cmd.take   = 1'b0;
        cmd.op     = mmh_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (stat.empty)
                    begin
                        state_next = S_FINAL;
                    end
                    else if (stat.absorb && stat.word_full)
                    begin
                        state_next = S_MIX_K1;
                        done_next  = stat.last;
                    end
                    else if (stat.absorb && stat.last)
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_MIX_K1:
            begin
                cmd.op     = mmh_pkg::OP_MIX_K1;
                state_next = S_MIX_K2;
            end
            S_MIX_K2:
            begin
                cmd.op     = mmh_pkg::OP_MIX_K2;
                state_next = S_MIX_H;
            end
            S_MIX_H:
            begin
                cmd.op     = mmh_pkg::OP_MIX_H;
                state_next = done_reg ? S_FINAL : S_IDLE;
                done_next  = 1'b0;
            end
            S_TAIL:
            begin
                cmd.op     = mmh_pkg::OP_TAIL;
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.op     = mmh_pkg::OP_FINAL;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = mmh_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                done_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

/* rtl/mmh_dp.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 datapath
// Byte packing, length tracking, shared mix multiplier and output register.
// ----------------------------------------------------------------------------
module mmh_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mmh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mmh_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [mmh_pkg::BYTE_W-1:0]        char_byte,
    input  logic                              start_of_message,
    input  logic [mmh_pkg::MSG_LEN_W-1:0]     message_length,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [mmh_pkg::HASH_W-1:0]        hash_value,
    input  mmh_pkg::mmh_cmd_t                 cmd,
    output mmh_pkg::mmh_stat_t                stat
);

    logic [mmh_pkg::HASH_W-1:0]      seed_reg;
    logic                            fold_reg;
    logic [mmh_pkg::HASH_W-1:0]      hash_reg;
    logic [mmh_pkg::HASH_W-1:0]      k_reg;
    logic [23:0]                     pend_reg;
    logic [1:0]                      cnt_reg;
    logic [mmh_pkg::LENGTH_BITS-1:0] rem_reg;
    logic                            active_reg;
    logic [mmh_pkg::HASH_W-1:0]      out_hash_reg;
    logic                            out_valid_reg;

    logic [mmh_pkg::BYTE_W-1:0]      byte_f;
    logic [mmh_pkg::LENGTH_BITS-1:0] len_ext;
    logic [mmh_pkg::LENGTH_BITS-1:0] rem_base;
    logic [mmh_pkg::LENGTH_BITS-1:0] rem_after;
    logic [23:0]                     pend_base;
    logic [1:0]                      cnt_base;
    logic [mmh_pkg::HASH_W-1:0]      word_new;
    logic [mmh_pkg::HASH_W-1:0]      mul_a;
    logic [mmh_pkg::HASH_W-1:0]      product;

    always_comb
    begin
        byte_f = char_byte;
        if (fold_reg && char_byte >= mmh_pkg::CHAR_UPPER_A
            && char_byte <= mmh_pkg::CHAR_UPPER_Z)
        begin
            byte_f = char_byte + mmh_pkg::CASE_OFFSET;
        end
        len_ext   = mmh_pkg::LENGTH_BITS'(message_length);
        rem_base  = start_of_message ? len_ext : rem_reg;
        pend_base = start_of_message ? 24'd0 : pend_reg;
        cnt_base  = start_of_message ? 2'd0 : cnt_reg;
        rem_after = rem_base - mmh_pkg::LENGTH_BITS'(1);
        word_new  = {8'd0, pend_base}
                    | (mmh_pkg::HASH_W'(byte_f) << {cnt_base, 3'b000});

        stat.empty     = start_of_message && (len_ext == '0);
        stat.absorb    = start_of_message ? (len_ext != '0)
                                          : (active_reg && (rem_reg != '0));
        stat.word_full = (cnt_base == 2'd3);
        stat.last      = (rem_after == '0);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        case (cmd.op)
            mmh_pkg::OP_MIX_K1: mul_a = k_reg;
            mmh_pkg::OP_MIX_K2: mul_a = k_reg ^ (k_reg >> mmh_pkg::MIX_SHIFT);
            mmh_pkg::OP_MIX_H:  mul_a = hash_reg;
            mmh_pkg::OP_TAIL:   mul_a = hash_reg ^ {8'd0, pend_reg};
            mmh_pkg::OP_FINAL:  mul_a = hash_reg ^ (hash_reg >> mmh_pkg::FINAL_SHIFT_A);
            default:            mul_a = '0;
        endcase
        product = mul_a * mmh_pkg::MIX_MUL;
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            fold_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mmh_pkg::REG_HASH_SEED: seed_reg <= cfg_data;
                mmh_pkg::REG_FOLD_CASE: fold_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg   <= '0;
            pend_reg   <= '0;
            cnt_reg    <= '0;
            rem_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            if (start_of_message)
            begin
                hash_reg <= seed_reg ^ mmh_pkg::HASH_W'(len_ext);
            end
            if (stat.empty)
            begin
                pend_reg   <= '0;
                cnt_reg    <= '0;
                rem_reg    <= '0;
                active_reg <= 1'b0;
            end
            else if (stat.absorb)
            begin
                if (stat.word_full)
                begin
                    pend_reg <= '0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    pend_reg <= word_new[23:0];
                    cnt_reg  <= cnt_base + 2'd1;
                end
                rem_reg    <= rem_after;
                active_reg <= !stat.last;
            end
        end
        else
        begin
            case (cmd.op)
                mmh_pkg::OP_MIX_H:
                begin
                    hash_reg <= product ^ k_reg;
                end
                mmh_pkg::OP_TAIL:
                begin
                    hash_reg <= product;
                end
                mmh_pkg::OP_FINAL:
                begin
                    hash_reg <= product;
                    pend_reg <= '0;
                    cnt_reg  <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // word under mix
    always_ff @(posedge clk)
    begin
        if (cmd.take && stat.absorb && stat.word_full && !stat.empty)
        begin
            k_reg <= word_new;
        end
        else if (cmd.op == mmh_pkg::OP_MIX_K1 || cmd.op == mmh_pkg::OP_MIX_K2)
        begin
            k_reg <= product;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == mmh_pkg::OP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == mmh_pkg::OP_EMIT)
        begin
            out_hash_reg <= hash_reg ^ (hash_reg >> mmh_pkg::FINAL_SHIFT_B);
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

endmodule

/* rtl/mmh_checker.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 port checker
// Port-level checks on handshake timing of the hash block.
// ----------------------------------------------------------------------------
module mmh_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           in_start,
    input logic [mmh_pkg::MSG_LEN_W-1:0]  in_len,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [mmh_pkg::HASH_W-1:0]     out_hash
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_hash))
        else $error("hash item dropped or changed while stalled");

    a_empty_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_start && in_len == '0 |=> !in_ready)
        else $error("empty message did not start finishing");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("hash item appeared while input was open");

endmodule

bind murmur2_string_hash_top mmh_checker u_mmh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .in_start  (item_in.start_of_message),
    .in_len    (item_in.message_length),
    .out_valid (hash_out.valid),
    .out_ready (hash_out.ready),
    .out_hash  (hash_out.hash_value)
);
